// File: hw/rtl/multi_slot_deadline_timer_top_assert.svh
// Assertion macros used by the timer top-level RTL file.
`ifndef MULTI_SLOT_DEADLINE_TIMER_TOP_ASSERT_SVH
`define MULTI_SLOT_DEADLINE_TIMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, skipped while reset is high.
`define MSDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MSDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSDT_ASSERT(lbl, clk, rst, prop, msg)
`define MSDT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/msdt_pkg.sv
// Package: payload structs, codes and constants of the deadline timer.
`timescale 1ns / 1ps
`default_nettype none
package msdt_pkg;

   localparam int TICK_W = 64;

   // operation codes
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_ARM      = 3'd1;
   localparam logic [2:0] OP_REGISTER = 3'd2;
   localparam logic [2:0] OP_STOP     = 3'd3;
   localparam logic [2:0] OP_SLEEP    = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_ACK       = 2'd0;
   localparam logic [1:0] KIND_EXPIRED   = 2'd1;
   localparam logic [1:0] KIND_PERIODIC  = 2'd2;
   localparam logic [1:0] KIND_TICK_DONE = 2'd3;

   localparam logic [7:0] STEP_RESET = 8'd2;

   // x / 1000 == (x * PERIOD_MAGIC) >> PERIOD_SHIFT for any 32-bit x
   localparam logic [9:0]  PERIOD       = 10'd1000;
   localparam logic [28:0] PERIOD_MAGIC = 29'd274877907;
   localparam int          PERIOD_SHIFT = 38;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] duration_ms;
      logic [3:0]  slot;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        slot_index;
      logic              ok;
      logic              sleeping;
      logic [TICK_W-1:0] tick_value;
      logic              last;
   } rsp_payload_type;

   // request to the shared add/compare unit (other operand is the count)
   typedef struct packed {
      logic [TICK_W-1:0] operand;
      logic              sub;
   } alu_req_type;

   typedef struct packed {
      logic [TICK_W-1:0] sum;
      logic              ge;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARM_ADD,
      ST_SLEEP_ADD,
      ST_RESP,
      ST_TICK_ADD,
      ST_TICK_SLEEP,
      ST_SCAN_CMP,
      ST_SCAN_PER,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// File: hw/rtl/msdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module msdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/msdt_alu.sv
// Shared 64-bit add / unsigned compare unit.
`timescale 1ns / 1ps
`default_nettype none
module msdt_alu (
   input  wire logic [msdt_pkg::TICK_W-1:0] count,
   input  wire msdt_pkg::alu_req_type       req,
   output msdt_pkg::alu_rsp_type            rsp
);
   import msdt_pkg::*;

   logic [TICK_W-1:0] operand_b;
   logic [TICK_W:0]   total;

   // subtract is count + ~b + 1; carry out means count >= b
   assign operand_b = req.sub ? ~req.operand : req.operand;
   assign total     = {1'b0, count} + {1'b0, operand_b} + {{TICK_W{1'b0}}, req.sub};

   assign rsp.sum = total[TICK_W-1:0];
   assign rsp.ge  = total[TICK_W];

endmodule
`default_nettype wire

// File: hw/rtl/msdt_period.sv
// Two-stage check that a 32-bit value is a multiple of 1000.
`timescale 1ns / 1ps
`default_nettype none
module msdt_period (
   input  wire logic        clock,
   input  wire logic [31:0] value,
   output logic             hit
);
   import msdt_pkg::*;

   logic [60:0] prod;
   logic [22:0] quot_ff;
   logic [31:0] value_ff;
   logic [31:0] back;
   logic        hit_ff;

   // stage 1: quotient by reciprocal multiply
   assign prod = 61'(value) * 61'(PERIOD_MAGIC);

   // stage 2: multiply back and compare
   assign back = 32'({9'b0, quot_ff} * 32'(PERIOD));

   always_ff @(posedge clock) begin
      quot_ff  <= prod[60:PERIOD_SHIFT];
      value_ff <= value;
      hit_ff   <= (back == value_ff);
   end

   assign hit = hit_ff;

endmodule
`default_nettype wire

// File: hw/rtl/multi_slot_deadline_timer_top.sv
// Top level: sequencer, slot tables and result register of the deadline timer.
//
// Channel   Dir  Handshake          Content
// req_*     in   valid / ready      operation, duration_ms, slot
// rsp_*     out  valid / ready      kind, slot_index, ok, sleeping, tick_value, last
// csr_*     in   write enable only  tick_step (8 bits)
//
// A tick adds the step, checks the sleep deadline, then scans each slot: a compare
// on the shared adder/comparator and a periodic check, deadline RAM read one slot
// ahead. Arm with a free slot and sleep add first; other requests reply directly.
// Each result waits while the output register is full and not taken. Reset is
// synchronous; the deadline store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_deadline_timer_top_assert.svh"
module multi_slot_deadline_timer_top #(
   parameter int SLOTS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire msdt_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output msdt_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                      csr_we,
   input  wire logic [7:0]                csr_wdata
);
   import msdt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // state
   state_type         state_ff, state_in;
   logic [7:0]        step_ff;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [SLOTS-1:0]  wait_valid_ff, wait_valid_in;
   logic [SLOTS-1:0]  per_valid_ff, per_valid_in;
   logic              sleep_act_ff, sleep_act_in;
   logic [TICK_W-1:0] sleep_dl_ff, sleep_dl_in;
   logic [31:0]       dur_ff, dur_in;
   logic [IDX_W-1:0]  alloc_ff, alloc_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [3:0]        ack_idx_ff, ack_idx_in;
   logic              ack_ok_ff, ack_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   // datapath nets
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   logic [TICK_W-1:0] ram_rdata;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic              per_hit;
   logic              out_free;
   logic              accept;
   logic              expired;
   logic              fire;
   logic              last_idx;
   logic              w_found, p_found;
   logic [IDX_W-1:0]  w_free, p_free;
   logic              stop_ok;
   logic              emit_en;
   logic [1:0]        emit_kind;
   logic [3:0]        emit_slot;
   logic              emit_ok;
   logic              emit_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign expired   = wait_valid_ff[idx_ff] && alu_rsp.ge;
   assign fire      = per_hit && per_valid_ff[idx_ff];
   assign last_idx  = (idx_ff == IDX_W'(SLOTS - 1));
   assign stop_ok   = ({2'b0, req_payload.slot} < 6'(SLOTS));

   // lowest free slot of each table
   always_comb begin
      w_found = 1'b0;
      w_free  = '0;
      p_found = 1'b0;
      p_free  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!wait_valid_ff[i]) begin
            w_found = 1'b1;
            w_free  = IDX_W'(i);
         end
         if (!per_valid_ff[i]) begin
            p_found = 1'b1;
            p_free  = IDX_W'(i);
         end
      end
   end

   // shared unit operand select
   always_comb begin
      alu_req.operand = ram_rdata;
      alu_req.sub     = 1'b1;
      unique case (state_ff)
         ST_TICK_ADD: begin
            alu_req.operand = {{(TICK_W - 8){1'b0}}, step_ff};
            alu_req.sub     = 1'b0;
         end
         ST_ARM_ADD, ST_SLEEP_ADD: begin
            alu_req.operand = {32'b0, dur_ff};
            alu_req.sub     = 1'b0;
         end
         ST_TICK_SLEEP: begin
            alu_req.operand = sleep_dl_ff;
         end
         default: begin
            alu_req.operand = ram_rdata;
         end
      endcase
   end

   msdt_alu u_alu (
      .count (tick_ff),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   msdt_ram #(
      .WIDTH (TICK_W),
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (alloc_ff),
      .wr_data (alu_rsp.sum),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   msdt_period u_period (
      .clock (clock),
      .value (tick_ff[31:0]),
      .hit   (per_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.operation)
                  OP_TICK:  state_in = ST_TICK_ADD;
                  OP_ARM:   state_in = w_found ? ST_ARM_ADD : ST_RESP;
                  OP_SLEEP: state_in = ST_SLEEP_ADD;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_ARM_ADD, ST_SLEEP_ADD: state_in = ST_RESP;
         ST_RESP, ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_ADD:   state_in = ST_TICK_SLEEP;
         ST_TICK_SLEEP: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (!expired || out_free) begin
               state_in = ST_SCAN_PER;
            end
         end
         ST_SCAN_PER: begin
            if (!fire || out_free) begin
               state_in = last_idx ? ST_DONE : ST_SCAN_CMP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath updates and result emission
   always_comb begin
      tick_in       = tick_ff;
      wait_valid_in = wait_valid_ff;
      per_valid_in  = per_valid_ff;
      sleep_act_in  = sleep_act_ff;
      sleep_dl_in   = sleep_dl_ff;
      dur_in        = dur_ff;
      alloc_in      = alloc_ff;
      idx_in        = idx_ff;
      ack_idx_in    = ack_idx_ff;
      ack_ok_in     = ack_ok_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      emit_en       = 1'b0;
      emit_kind     = KIND_ACK;
      emit_slot     = 4'd0;
      emit_ok       = 1'b1;
      emit_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dur_in     = req_payload.duration_ms;
               alloc_in   = w_free;
               ack_idx_in = 4'd0;
               ack_ok_in  = 1'b0;
               unique case (req_payload.operation)
                  OP_REGISTER: begin
                     if (p_found) begin
                        per_valid_in[p_free] = 1'b1;
                        ack_idx_in           = 4'(p_free);
                        ack_ok_in            = 1'b1;
                     end
                  end
                  OP_STOP: begin
                     if (stop_ok) begin
                        per_valid_in[IDX_W'(req_payload.slot)] = 1'b0;
                        ack_idx_in = req_payload.slot;
                        ack_ok_in  = 1'b1;
                     end
                  end
                  default: begin
                     ack_ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_ARM_ADD: begin
            ram_wr_en               = 1'b1;
            wait_valid_in[alloc_ff] = 1'b1;
            ack_idx_in              = 4'(alloc_ff);
            ack_ok_in               = 1'b1;
         end
         ST_SLEEP_ADD: begin
            sleep_dl_in  = alu_rsp.sum;
            sleep_act_in = 1'b1;
            ack_idx_in   = 4'd0;
            ack_ok_in    = 1'b1;
         end
         ST_RESP: begin
            emit_en   = out_free;
            emit_kind = KIND_ACK;
            emit_slot = ack_idx_ff;
            emit_ok   = ack_ok_ff;
            emit_last = 1'b1;
         end
         ST_TICK_ADD: begin
            tick_in = alu_rsp.sum;
         end
         ST_TICK_SLEEP: begin
            // clear sleep once reached; fetch slot 0 deadline
            if (sleep_act_ff && alu_rsp.ge) begin
               sleep_act_in = 1'b0;
            end
            idx_in    = '0;
            ram_rd_en = 1'b1;
         end
         ST_SCAN_CMP: begin
            if (expired && out_free) begin
               emit_en               = 1'b1;
               emit_kind             = KIND_EXPIRED;
               emit_slot             = 4'(idx_ff);
               wait_valid_in[idx_ff] = 1'b0;
            end
         end
         ST_SCAN_PER: begin
            if (fire && out_free) begin
               emit_en   = 1'b1;
               emit_kind = KIND_PERIODIC;
               emit_slot = 4'(idx_ff);
            end
            // advance and prefetch next deadline
            if ((!fire || out_free) && !last_idx) begin
               idx_in    = idx_ff + IDX_W'(1);
               ram_rd_en = 1'b1;
            end
         end
         ST_DONE: begin
            emit_en   = out_free;
            emit_kind = KIND_TICK_DONE;
            emit_last = 1'b1;
         end
         default: begin
            emit_en = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_en) begin
         rsp_valid_in      = 1'b1;
         rsp_in.kind       = emit_kind;
         rsp_in.slot_index = emit_slot;
         rsp_in.ok         = emit_ok;
         rsp_in.sleeping   = sleep_act_ff;
         rsp_in.tick_value = tick_ff;
         rsp_in.last       = emit_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= STEP_RESET;
         tick_ff       <= '0;
         wait_valid_ff <= '0;
         per_valid_ff  <= '0;
         sleep_act_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            step_ff <= csr_wdata;
         end
         tick_ff       <= tick_in;
         wait_valid_ff <= wait_valid_in;
         per_valid_ff  <= per_valid_in;
         sleep_act_ff  <= sleep_act_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sleep_dl_ff <= sleep_dl_in;
      dur_ff      <= dur_in;
      alloc_ff    <= alloc_in;
      idx_ff      <= idx_in;
      ack_idx_ff  <= ack_idx_in;
      ack_ok_ff   <= ack_ok_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `MSDT_ASSERT(a_emit_room, clock, reset, emit_en |-> out_free, "item emitted over a held result")
   `MSDT_ASSERT(a_expire_frees, clock, reset, (emit_en && emit_kind == KIND_EXPIRED) |=> !wait_valid_ff[$past(idx_ff)], "expired slot not freed")
   `MSDT_ASSERT(a_sleep_source, clock, reset, (!sleep_act_ff && state_ff != ST_SLEEP_ADD) |=> !sleep_act_ff, "sleep armed without a request")
   `MSDT_ASSERT(a_tick_close, clock, reset, (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && rsp_ff.last && rsp_ff.kind == KIND_TICK_DONE), "tick not closed by tick-done item")

endmodule
`default_nettype wire
